[rtl/mlm_pkg.sv]
// shared constants for the multiprecision limb multiplier
`timescale 1ns / 1ps

package mlm_pkg;

    localparam int MAX_LIMBS_DEF  = 16;
    localparam int LIMB_BITS_DEF  = 32;
    localparam int DIGIT_BITS     = 8;

    localparam int A_LIMBS_W      = 5;
    localparam int A_LIMBS_RESET  = 16;
    localparam int A_INDEX_W      = 4;
    localparam int LIMB_W         = 32;

    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 32;

    localparam logic MODE_LOAD_A  = 1'b0;
    localparam logic MODE_FEED_B  = 1'b1;

endpackage

[rtl/multiprecision_limb_multiplier_unit.sv]
// schoolbook multiprecision multiplier with a digit-serial multiply-accumulate datapath
`timescale 1ns / 1ps

//  channel   direction  fields (low bit first)                           transfer
//  s_axis    in         tdata: a_index[3:0], limb_value[35:4]            tvalid & tready
//                       tuser: mode, tlast: last_b
//  m_axis    out        tdata: product_limb[31:0], tlast: last_limb      tvalid & tready
//  cfg       in         data: a_limbs[4:0]                               valid & ready
//
//  a B limb runs S_FETCH, K = ceil(LIMB_BITS/8) digit steps of the shared LIMB_BITS x 8
//  multiplier in S_MAC and S_PUSH for each used A limb, then S_TAIL, then S_OUT, which
//  emits the product limbs (1, or na+1 on the last B limb)
//  reset clears the partial row and sets a_limbs to 16; the A store is not cleared
//  a stalled m_axis holds the emit phase; s_axis is ready only while idle

module multiprecision_limb_multiplier_unit #(
    parameter int MAX_LIMBS = mlm_pkg::MAX_LIMBS_DEF,
    parameter int LIMB_BITS = mlm_pkg::LIMB_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mlm_pkg::S_TDATA_W-1:0] s_axis_tdata,   // a_index, limb_value
    input  logic                          s_axis_tuser,   // mode
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mlm_pkg::M_TDATA_W-1:0] m_axis_tdata,   // product_limb
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mlm_pkg::A_LIMBS_W-1:0] i_cfg_data      // a_limbs
);

    localparam int LB   = LIMB_BITS;
    localparam int DIG  = mlm_pkg::DIGIT_BITS;
    localparam int NDIG = (LB + DIG - 1) / DIG;
    localparam int BW   = NDIG * DIG;
    localparam int DCW  = $clog2(NDIG);
    localparam int ROW  = MAX_LIMBS + 1;
    localparam int AW   = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
    localparam int IXW  = $clog2(MAX_LIMBS + 2);
    localparam int CW   = (IXW > mlm_pkg::A_LIMBS_W) ? IXW : mlm_pkg::A_LIMBS_W;
    localparam int XAW  = AW + mlm_pkg::A_INDEX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_PUSH  = 3'd3;
    localparam logic [2:0] S_TAIL  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                      r_state,  n_state;
    logic [mlm_pkg::A_LIMBS_W-1:0]   r_a_limbs;
    logic [IXW-1:0]                  r_idx,    n_idx;
    logic [IXW-1:0]                  r_na,     n_na;
    logic [DCW-1:0]                  r_dig,    n_dig;
    logic                            r_last,   n_last;
    logic [BW-1:0]                   r_b,      n_b;
    logic [BW-1:0]                   r_emit,   n_emit;
    logic [LB:0]                     r_acc,    n_acc;
    logic [LB-1:0]                   r_carry,  n_carry;
    logic [LB-1:0]                   r_row [ROW];
    logic [LB-1:0]                   n_row [ROW];
    logic                            r_m_valid, n_m_valid;
    logic [mlm_pkg::M_TDATA_W-1:0]   r_m_data,  n_m_data;
    logic                            r_m_last,  n_m_last;

    logic [LB-1:0]                   mem [MAX_LIMBS];
    logic [LB-1:0]                   r_a_rd;

    logic                            w_in_xfer;
    logic [mlm_pkg::A_INDEX_W-1:0]   w_a_index;
    logic [LB-1:0]                   w_limb;
    logic [XAW-1:0]                  w_widx;
    logic                            w_wr_en;
    logic                            w_rd_ok;
    logic [CW-1:0]                   w_len;
    logic [CW-1:0]                   w_na;
    logic [LB+DIG-1:0]               w_prod;
    logic [LB+DIG:0]                 w_sum;
    logic [LB+BW:0]                  w_cat;
    logic                            w_push;
    logic [LB-1:0]                   w_push_val;
    logic                            w_clear;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;
    assign w_a_index = s_axis_tdata[mlm_pkg::A_INDEX_W-1:0];
    assign w_limb    = s_axis_tdata[mlm_pkg::A_INDEX_W +: LB];
    assign w_widx    = XAW'(w_a_index);
    assign w_wr_en   = w_in_xfer && (s_axis_tuser == mlm_pkg::MODE_LOAD_A)
                       && (w_widx < XAW'(MAX_LIMBS));
    assign w_rd_ok   = (r_idx < IXW'(MAX_LIMBS));

    // used length: zero taken as one, clipped to the store depth
    assign w_len = CW'(r_a_limbs);
    assign w_na  = (w_len == '0) ? CW'(1) :
                   (w_len > CW'(MAX_LIMBS)) ? CW'(MAX_LIMBS) : w_len;

    // one digit of b against one A limb
    assign w_prod = r_a_rd * r_b[DIG-1:0];
    assign w_sum  = {{DIG{1'b0}}, r_acc} + {1'b0, w_prod};
    assign w_cat  = {r_acc, r_emit};

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_na      = r_na;
        n_dig     = r_dig;
        n_last    = r_last;
        n_b       = r_b;
        n_emit    = r_emit;
        n_acc     = r_acc;
        n_carry   = r_carry;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;
        w_push    = 1'b0;
        w_push_val = '0;
        w_clear   = 1'b0;

        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (s_axis_tuser == mlm_pkg::MODE_FEED_B)) begin
                    n_b     = BW'(w_limb);
                    n_last  = s_axis_tlast;
                    n_na    = w_na[IXW-1:0];
                    n_idx   = '0;
                    n_carry = '0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_acc   = {1'b0, r_row[0]} + {1'b0, r_carry};
                n_dig   = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                n_acc  = w_sum[LB+DIG:DIG];
                n_emit = {w_sum[DIG-1:0], r_emit[BW-1:DIG]};
                n_b    = {r_b[DIG-1:0], r_b[BW-1:DIG]};
                if (r_dig == DCW'(NDIG - 1)) begin
                    n_state = S_PUSH;
                end else begin
                    n_dig = r_dig + DCW'(1);
                end
            end
            S_PUSH: begin
                w_push     = 1'b1;
                w_push_val = r_emit[LB-1:0];
                n_carry    = w_cat[2*LB-1:LB];
                n_idx      = r_idx + IXW'(1);
                if ((r_idx + IXW'(1)) == r_na) begin
                    n_state = S_TAIL;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_TAIL: begin
                w_push     = 1'b1;
                w_push_val = (r_idx == r_na) ? r_carry : r_row[0];
                if (r_idx == IXW'(ROW - 1)) begin
                    n_idx   = '0;
                    n_state = S_OUT;
                end else begin
                    n_idx = r_idx + IXW'(1);
                end
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_data   = mlm_pkg::M_TDATA_W'(r_row[0]);
                    n_m_last   = r_last && (r_idx == r_na);
                    w_push     = 1'b1;
                    w_push_val = '0;
                    n_idx      = r_idx + IXW'(1);
                    if (!r_last || (r_idx == r_na)) begin
                        w_clear = r_last;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        for (int k = 0; k < ROW; k++) begin
            n_row[k] = r_row[k];
        end
        if (w_clear) begin
            for (int k = 0; k < ROW; k++) begin
                n_row[k] = '0;
            end
        end else if (w_push) begin
            for (int k = 0; k < ROW - 1; k++) begin
                n_row[k] = r_row[k+1];
            end
            n_row[ROW-1] = w_push_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_a_limbs <= mlm_pkg::A_LIMBS_W'(mlm_pkg::A_LIMBS_RESET);
            r_idx     <= '0;
            r_na      <= '0;
            r_dig     <= '0;
            r_last    <= 1'b0;
            r_carry   <= '0;
            r_m_valid <= 1'b0;
            for (int k = 0; k < ROW; k++) begin
                r_row[k] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_na      <= n_na;
            r_dig     <= n_dig;
            r_last    <= n_last;
            r_carry   <= n_carry;
            r_m_valid <= n_m_valid;
            for (int k = 0; k < ROW; k++) begin
                r_row[k] <= n_row[k];
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_a_limbs <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b      <= n_b;
        r_emit   <= n_emit;
        r_acc    <= n_acc;
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
    end

    // operand A store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_widx[AW-1:0]] <= w_limb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_ok) begin
            r_a_rd <= mem[r_idx[AW-1:0]];
        end
    end

endmodule

[sim/tb_multiprecision_limb_multiplier_unit.sv]
// self-checking testbench for the multiprecision limb multiplier unit
`timescale 1ns / 1ps

module tb_multiprecision_limb_multiplier_unit;

    localparam int STORE_DEPTH  = mlm_pkg::MAX_LIMBS_DEF;
    localparam int ROW_LIMBS    = mlm_pkg::MAX_LIMBS_DEF + 1;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_WAIT  = 200;
    localparam int RANDOM_ITEMS = 320;

    typedef struct {
        logic                          mode;
        logic [mlm_pkg::A_INDEX_W-1:0] a_index;
        logic [mlm_pkg::LIMB_W-1:0]    limb;
        logic                          last_b;
    } t_limb_item;

    typedef struct {
        logic [mlm_pkg::LIMB_W-1:0] limb;
        logic                       last;
    } t_product_limb;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mlm_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;   // a_index, limb_value
    logic                          s_axis_tuser = 1'b0; // mode
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mlm_pkg::M_TDATA_W-1:0] m_axis_tdata;        // product_limb
    logic                          m_axis_tlast;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [mlm_pkg::A_LIMBS_W-1:0] i_cfg_data = '0;     // a_limbs

    multiprecision_limb_multiplier_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [mlm_pkg::LIMB_W-1:0]    a_copy [STORE_DEPTH];
    logic [mlm_pkg::LIMB_W-1:0]    row_copy [ROW_LIMBS];
    logic [mlm_pkg::A_LIMBS_W-1:0] a_limbs_cfg = mlm_pkg::A_LIMBS_W'(mlm_pkg::A_LIMBS_RESET);

    t_limb_item    item_q [$];
    t_product_limb product_q [$];
    t_limb_item    cur_item;

    int  src_gap = 0;
    int  snk_gap = 0;
    bit  src_bursty = 1'b1;
    bit  snk_bursty = 1'b1;
    int  err_count = 0;
    int  n_loads = 0;
    int  n_b_limbs = 0;
    int  n_results = 0;
    int  n_products = 0;
    int  n_cfg = 0;
    int  quiet_cycles = 0;

    function automatic void predict_product_limbs(input t_limb_item it);
        int unsigned                na;
        logic [63:0]                acc;
        logic [mlm_pkg::LIMB_W-1:0] carry;
        t_product_limb              pl;
        if (it.mode == mlm_pkg::MODE_LOAD_A) begin
            a_copy[it.a_index] = it.limb;
            return;
        end
        if (a_limbs_cfg == 0) begin
            na = 1;
        end else if (a_limbs_cfg > STORE_DEPTH) begin
            na = STORE_DEPTH;
        end else begin
            na = a_limbs_cfg;
        end
        carry = '0;
        for (int i = 0; i < na; i++) begin
            acc = 64'(row_copy[i]) + 64'(a_copy[i]) * 64'(it.limb) + 64'(carry);
            row_copy[i] = acc[31:0];
            carry = acc[63:32];
        end
        row_copy[na] = carry;
        if (!it.last_b) begin
            pl.limb = row_copy[0];
            pl.last = 1'b0;
            product_q.push_back(pl);
            for (int i = 0; i < ROW_LIMBS - 1; i++) row_copy[i] = row_copy[i + 1];
            row_copy[ROW_LIMBS - 1] = '0;
        end else begin
            for (int i = 0; i <= na; i++) begin
                pl.limb = row_copy[i];
                pl.last = (i == na);
                product_q.push_back(pl);
            end
            for (int i = 0; i < ROW_LIMBS; i++) row_copy[i] = '0;
        end
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_product_limbs(cur_item);
                if (cur_item.mode == mlm_pkg::MODE_LOAD_A) n_loads++;
                else n_b_limbs++;
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (item_q.size() > 0) begin
                    if (src_bursty && $urandom_range(0, 5) == 0) begin
                        src_gap = $urandom_range(1, 17) - 1;
                        s_axis_tvalid <= 1'b0;
                    end else begin
                        cur_item = item_q.pop_front();
                        s_axis_tdata  <= {4'b0, cur_item.limb, cur_item.a_index};
                        s_axis_tuser  <= cur_item.mode;
                        s_axis_tlast  <= cur_item.last_b;
                        s_axis_tvalid <= 1'b1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (product_q.size() == 0) begin
                $error("unexpected product limb %h last %b", m_axis_tdata, m_axis_tlast);
                err_count++;
            end else begin
                if (m_axis_tdata !== product_q[0].limb) begin
                    $error("product_limb expected %h actual %h",
                           product_q[0].limb, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== product_q[0].last) begin
                    $error("last_limb expected %b actual %b",
                           product_q[0].last, m_axis_tlast);
                    err_count++;
                end
                if (product_q[0].last) n_products++;
                void'(product_q.pop_front());
            end
        end
        if (snk_gap > 0) begin
            snk_gap--;
            m_axis_tready <= 1'b0;
        end else if (snk_bursty && $urandom_range(0, 7) == 0) begin
            snk_gap = $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("multiprecision_limb_multiplier_unit verification failed");
            $finish;
        end
    end

    task automatic push_item(input logic mode, input int idx, input logic [31:0] limb,
                             input logic last_b);
        t_limb_item it;
        it.mode    = mode;
        it.a_index = idx[mlm_pkg::A_INDEX_W-1:0];
        it.limb    = limb;
        it.last_b  = last_b;
        item_q.push_back(it);
    endtask

    function automatic logic [31:0] rand_limb();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 32'hFFFF_FFFF;
        if (pick == 1) return 32'h0;
        if (pick == 2) return 32'h8000_0000 | $urandom_range(0, 15);
        return $urandom;
    endfunction

    // wait until every item is taken and every product limb has arrived
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (item_q.size() != 0 || s_axis_tvalid || product_q.size() != 0);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_a_limbs(input logic [mlm_pkg::A_LIMBS_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        a_limbs_cfg = v;
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [mlm_pkg::A_LIMBS_W-1:0] fixed_cfg [5];
        logic [mlm_pkg::A_LIMBS_W-1:0] cfg;
        int random_items;
        int phase;
        int n_prod;
        int b_len;
        logic last_flag;

        fixed_cfg = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd17};
        for (int i = 0; i < STORE_DEPTH; i++) a_copy[i] = '0;
        for (int i = 0; i < ROW_LIMBS; i++) row_copy[i] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-width operands, all-ones carry chains, zero limbs
        write_a_limbs(5'd16);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i == 7) push_item(mlm_pkg::MODE_LOAD_A, i, 32'h0, 1'b0);
            else if (i == 3) push_item(mlm_pkg::MODE_LOAD_A, i, 32'h1, 1'b0);
            else push_item(mlm_pkg::MODE_LOAD_A, i, 32'hFFFF_FFFF, i == 15);
        end
        push_item(mlm_pkg::MODE_FEED_B, 0, 32'hFFFF_FFFF, 1'b0);
        push_item(mlm_pkg::MODE_FEED_B, 0, 32'hFFFF_FFFF, 1'b1);
        push_item(mlm_pkg::MODE_FEED_B, 15, 32'h0, 1'b1);
        wait_quiet();

        // directed: length change and store write in the middle of a product
        write_a_limbs(5'd3);
        push_item(mlm_pkg::MODE_FEED_B, 0, 32'h8000_0000, 1'b0);
        wait_quiet();
        write_a_limbs(5'd5);
        push_item(mlm_pkg::MODE_LOAD_A, 2, 32'hDEAD_BEEF, 1'b1);
        push_item(mlm_pkg::MODE_FEED_B, 0, 32'h1, 1'b1);
        wait_quiet();

        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (phase < 5) begin
                cfg = fixed_cfg[phase];
            end else if ($urandom_range(0, 3) == 0) begin
                cfg = mlm_pkg::A_LIMBS_W'($urandom_range(0, 31));
            end else begin
                cfg = mlm_pkg::A_LIMBS_W'($urandom_range(1, 4));
            end
            if (random_items >= RANDOM_ITEMS - 40) begin
                src_bursty = 1'b0;
                snk_bursty = 1'b0;
            end else begin
                src_bursty = ($urandom_range(0, 3) != 0);
                snk_bursty = ($urandom_range(0, 3) != 0);
            end
            write_a_limbs(cfg);
            n_prod = $urandom_range(1, 4);
            for (int p = 0; p < n_prod; p++) begin
                for (int k = $urandom_range(0, 3); k > 0; k--) begin
                    push_item(mlm_pkg::MODE_LOAD_A, $urandom_range(0, 15), rand_limb(),
                              1'($urandom_range(0, 1)));
                    random_items++;
                end
                b_len = $urandom_range(1, 5);
                for (int b = 0; b < b_len; b++) begin
                    last_flag = (b == b_len - 1);
                    // leave some products open so the next setting meets a partial row
                    if (last_flag && p == n_prod - 1 && $urandom_range(0, 4) == 0)
                        last_flag = 1'b0;
                    push_item(mlm_pkg::MODE_FEED_B, $urandom_range(0, 15), rand_limb(),
                              last_flag);
                    random_items++;
                    if ($urandom_range(0, 9) == 0) begin
                        push_item(mlm_pkg::MODE_LOAD_A, $urandom_range(0, 15), rand_limb(),
                                  1'($urandom_range(0, 1)));
                        random_items++;
                    end
                end
            end
            wait_quiet();
            phase++;
        end

        wait_quiet();
        $display("covered %0d A loads, %0d B limbs, %0d length settings",
                 n_loads, n_b_limbs, n_cfg);
        $display("checked %0d product limbs in %0d completed products",
                 n_results, n_products);
        if (err_count == 0) begin
            $display("multiprecision_limb_multiplier_unit verification clean");
        end else begin
            $display("multiprecision_limb_multiplier_unit verification failed");
        end
        $finish;
    end

endmodule
